@@ hw/rtl/wavhdr_pkg.sv @@
`timescale 1ns / 1ps

package wavhdr_pkg;

    localparam int unsigned POS_WIDTH = 32;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [POS_WIDTH-1:0] MIN_SIZE = POS_WIDTH'(44);
    localparam logic [31:0]          MIN_FMT  = 32'd16;
    localparam logic [31:0]          HDR_LEN  = 32'd8;

    localparam logic [POS_WIDTH-1:0] POS_RIFF_END = POS_WIDTH'(3);
    localparam logic [POS_WIDTH-1:0] POS_WAVE_END = POS_WIDTH'(11);

    localparam logic [4:0] FMT_OFF_END = 5'd16;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_SHORT = 2'd1;
    localparam t_status ST_BAD   = 2'd2;

    typedef enum logic [5:0] {
        PH_HEAD = 6'b000001,
        PH_CHDR = 6'b000010,
        PH_BODY = 6'b000100,
        PH_PAD  = 6'b001000,
        PH_DONE = 6'b010000,
        PH_ERR  = 6'b100000
    } t_phase;

endpackage

@@ hw/rtl/wav_riff_header_parser_core.sv @@
// output: o_valid rises once the final word of a buffer has passed the input register and reached the result register
// throughput: one word per cycle, set by the single update pass between the
// input register and the result register; a final word waits while the result register is held
// reset: synchronous active-low i_rst_n clears the parse state and both valids
// parse state also returns to its reset values after each final word
`timescale 1ns / 1ps

module wav_riff_header_parser_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_ready,
    output wavhdr_pkg::t_status       o_status,
    output logic                      o_valid_res,
    output logic [15:0]               o_wave_format,
    output logic [15:0]               o_channels,
    output logic [31:0]               o_rate_hz,
    output logic [15:0]               o_sample_width,
    output logic [31:0]               o_body_offset,
    output logic [31:0]               o_body_length
);
    import wavhdr_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parse state
    logic [POS_WIDTH-1:0] r_pos,   n_pos;
    t_phase               r_phase, n_phase;
    logic [31:0]          r_tag,   n_tag;
    logic [31:0]          r_len,   n_len;
    logic [31:0]          r_left,  n_left;
    logic                 r_pad,   n_pad;
    logic [4:0]           r_foff,  n_foff;
    logic [15:0]          r_fmt,   n_fmt;
    logic [15:0]          r_chan,  n_chan;
    logic [31:0]          r_rate,  n_rate;
    logic [15:0]          r_bits,  n_bits;
    logic [31:0]          r_dstart, n_dstart;
    logic [31:0]          r_dlen,  n_dlen;
    logic [1:0]           r_seen,  n_seen;
    logic                 r_err,   n_err;

    // result register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [15:0] r_out_fmt;
    logic [15:0] r_out_chan;
    logic [31:0] r_out_rate;
    logic [15:0] r_out_bits;
    logic [31:0] r_out_doff;
    logic [31:0] r_out_dsize;

    t_status n_status;
    logic    out_free;
    logic    stage_fire;
    logic    res_fire;

    assign out_free   = !r_out_valid || i_ready;
    assign stage_fire = r_in_valid && (!r_in_last || out_free);
    assign res_fire   = stage_fire && r_in_last;
    assign o_ready    = !r_in_valid || stage_fire;

    always_comb begin
        n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_len    = r_len;
        n_left   = r_left;
        n_pad    = r_pad;
        n_foff   = r_foff;
        n_fmt    = r_fmt;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_bits   = r_bits;
        n_dstart = r_dstart;
        n_dlen   = r_dlen;
        n_seen   = r_seen;
        n_err    = r_err;

        unique case (r_phase)
            PH_HEAD: begin
                n_tag = {r_tag[23:0], r_in_byte};
                if (r_pos == POS_RIFF_END && n_tag != TAG_RIFF) begin
                    n_err   = 1'b1;
                    n_phase = PH_ERR;
                end else if (r_pos == POS_WAVE_END) begin
                    if (n_tag != TAG_WAVE) begin
                        n_err   = 1'b1;
                        n_phase = PH_ERR;
                    end else begin
                        n_phase = PH_CHDR;
                        n_left  = HDR_LEN;
                        n_tag   = '0;
                        n_len   = '0;
                    end
                end
            end
            PH_CHDR: begin
                if (r_left > 32'd4) begin
                    n_tag = {r_tag[23:0], r_in_byte};
                end else begin
                    n_len = {r_in_byte, r_len[31:8]};
                end
                n_left = r_left - 1'b1;
                if (r_left == 32'd1) begin
                    n_pad  = n_len[0];
                    n_foff = '0;
                    if (n_tag == TAG_FMT) begin
                        if (n_len < MIN_FMT) begin
                            n_err   = 1'b1;
                            n_phase = PH_ERR;
                        end else begin
                            n_left  = n_len;
                            n_phase = PH_BODY;
                        end
                    end else if (n_tag == TAG_DATA) begin
                        n_dstart = 32'(n_pos);
                        n_dlen   = n_len;
                        n_seen   = r_seen | 2'b10;
                        n_phase  = PH_DONE;
                    end else if (n_len == 32'd0) begin
                        n_phase = PH_CHDR;
                        n_left  = HDR_LEN;
                        n_tag   = '0;
                        n_len   = '0;
                    end else begin
                        n_left  = n_len;
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (r_tag == TAG_FMT) begin
                    case (r_foff)
                        5'd0:    n_fmt[7:0]    = r_in_byte;
                        5'd1:    n_fmt[15:8]   = r_in_byte;
                        5'd2:    n_chan[7:0]   = r_in_byte;
                        5'd3:    n_chan[15:8]  = r_in_byte;
                        5'd4:    n_rate[7:0]   = r_in_byte;
                        5'd5:    n_rate[15:8]  = r_in_byte;
                        5'd6:    n_rate[23:16] = r_in_byte;
                        5'd7:    n_rate[31:24] = r_in_byte;
                        5'd14:   n_bits[7:0]   = r_in_byte;
                        5'd15:   n_bits[15:8]  = r_in_byte;
                        default: ;
                    endcase
                    if (r_foff != FMT_OFF_END) begin
                        n_foff = r_foff + 1'b1;
                    end
                end
                n_left = r_left - 1'b1;
                if (r_left == 32'd1) begin
                    if (r_tag == TAG_FMT) begin
                        n_seen = r_seen | 2'b01;
                    end
                    if (r_pad) begin
                        n_phase = PH_PAD;
                    end else begin
                        n_phase = PH_CHDR;
                        n_left  = HDR_LEN;
                        n_tag   = '0;
                        n_len   = '0;
                    end
                end
            end
            PH_PAD: begin
                n_pad   = 1'b0;
                n_phase = PH_CHDR;
                n_left  = HDR_LEN;
                n_tag   = '0;
                n_len   = '0;
            end
            default: ;
        endcase

        if (n_pos < MIN_SIZE) begin
            n_status = ST_SHORT;
        end else if (n_err) begin
            n_status = ST_BAD;
        end else if (n_phase == PH_BODY && n_tag == TAG_FMT) begin
            n_status = ST_BAD;
        end else if (n_seen != 2'b11) begin
            n_status = ST_BAD;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || res_fire) begin
            r_pos    <= '0;
            r_phase  <= PH_HEAD;
            r_tag    <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_pad    <= 1'b0;
            r_foff   <= '0;
            r_fmt    <= '0;
            r_chan   <= '0;
            r_rate   <= '0;
            r_bits   <= '0;
            r_dstart <= '0;
            r_dlen   <= '0;
            r_seen   <= '0;
            r_err    <= 1'b0;
        end else if (stage_fire) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_left   <= n_left;
            r_pad    <= n_pad;
            r_foff   <= n_foff;
            r_fmt    <= n_fmt;
            r_chan   <= n_chan;
            r_rate   <= n_rate;
            r_bits   <= n_bits;
            r_dstart <= n_dstart;
            r_dlen   <= n_dlen;
            r_seen   <= n_seen;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_out_status <= n_status;
            if (n_status == ST_OK) begin
                r_out_fmt   <= n_fmt;
                r_out_chan  <= n_chan;
                r_out_rate  <= n_rate;
                r_out_bits  <= n_bits;
                r_out_doff  <= n_dstart;
                r_out_dsize <= n_dlen;
            end else begin
                r_out_fmt   <= '0;
                r_out_chan  <= '0;
                r_out_rate  <= '0;
                r_out_bits  <= '0;
                r_out_doff  <= '0;
                r_out_dsize <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_valid_res    = (r_out_status == ST_OK);
    assign o_wave_format  = r_out_fmt;
    assign o_channels     = r_out_chan;
    assign o_rate_hz      = r_out_rate;
    assign o_sample_width = r_out_bits;
    assign o_body_offset  = r_out_doff;
    assign o_body_length  = r_out_dsize;

    // a failed header reports all fields as zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_rate_hz == '0 && o_body_offset == '0 && o_body_length == '0
             && o_wave_format == '0))
        else $error("nonzero fields on failed header");

    // final word puts the parser back to its start
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_fire |=> (r_phase == PH_HEAD && r_pos == '0 && r_seen == 2'b00))
        else $error("parse state not cleared after final word");

    // data chunk found ends the walk for good
    a_data_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen[1] |-> (r_phase == PH_DONE && !r_err))
        else $error("data seen outside done phase");

    // a pending final word is never dropped while the result register is full
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !i_ready) |=>
            (r_in_valid && r_in_last && r_out_valid))
        else $error("final word lost under output stall");

endmodule
